/* rtl/nd_array_linear_offset_core_defines.svh */
// ---------------------------------------------------------------------------
// nd array linear offset core assertion macros
// shared concurrent assertion forms for the offset generator
// ---------------------------------------------------------------------------
`ifndef ND_ARRAY_LINEAR_OFFSET_CORE_DEFINES_SVH
`define ND_ARRAY_LINEAR_OFFSET_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NALO_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("nalo same-cycle check failed");

// next-cycle implication, disabled while in reset
`define NALO_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("nalo next-cycle check failed");

`endif

/* rtl/nalo_pkg.sv */
// ---------------------------------------------------------------------------
// nalo_pkg
// shared widths, types and register codes of the nd array offset generator
// ---------------------------------------------------------------------------
`default_nettype none

package nalo_pkg;

    localparam int OFS_W      = 60;
    localparam int SIZE_W     = 11;
    localparam int COUNT_W    = 3;
    localparam int FIELD_DIMS = 6;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 4;

    typedef logic [OFS_W-1:0]     offset_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_DIM_COUNT   = 4'd0;
    localparam cfg_idx_t REG_LAYOUT_MODE = 4'd1;
    localparam cfg_idx_t REG_SIZE_BASE   = 4'd2;
    localparam cfg_idx_t REG_COUNT       = 4'd8;

    // layout codes
    localparam logic LAYOUT_COL = 1'b0;
    localparam logic LAYOUT_ROW = 1'b1;

    // reset configuration
    localparam count_t RST_DIM_COUNT = 3'd3;
    localparam size_t  RST_SIZE      = 11'd1;

endpackage

`default_nettype wire

/* rtl/nalo_stride_gen.sv */
// ---------------------------------------------------------------------------
// nalo_stride_gen
// configuration registers and sequential stride table rebuild
// ---------------------------------------------------------------------------
`default_nettype none

module nalo_stride_gen #(
    parameter int LANES = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  nalo_pkg::cfg_idx_t     cfg_index,
    input  nalo_pkg::size_t        cfg_data,
    output logic                   busy,
    output nalo_pkg::offset_t      stride [LANES]
);
    import nalo_pkg::*;

    count_t  dim_count_reg, dim_count_next;
    logic    layout_reg, layout_next;
    size_t   size_reg [FIELD_DIMS];
    logic    busy_reg, busy_next;
    step_t   step_reg, step_next;
    offset_t acc_reg, acc_next;
    offset_t stride_reg [LANES];

    count_t  dims_use;
    step_t   k;
    logic    in_use;
    size_t   size_sel;
    logic [OFS_W+SIZE_W-1:0] prod;
    logic    start;

    assign start    = cfg_we && (cfg_index < REG_COUNT);
    assign dims_use = (dim_count_reg > COUNT_W'(LANES)) ? COUNT_W'(LANES) : dim_count_reg;
    // column-major walks up from dimension zero, row-major walks down
    assign k        = (layout_reg == LAYOUT_ROW) ? (step_t'(FIELD_DIMS - 1) - step_reg)
                                                 : step_reg;
    assign in_use   = (COUNT_W'(k) < dims_use);
    assign size_sel = size_reg[k];
    assign prod     = acc_reg * size_sel;

    always_comb
    begin
        dim_count_next = dim_count_reg;
        layout_next    = layout_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        if (cfg_we && (cfg_index == REG_DIM_COUNT))
        begin
            dim_count_next = cfg_data[COUNT_W-1:0];
        end
        if (cfg_we && (cfg_index == REG_LAYOUT_MODE))
        begin
            layout_next = cfg_data[0];
        end
        if (busy_reg)
        begin
            acc_next  = in_use ? prod[OFS_W-1:0] : OFS_W'(1);
            step_next = step_reg + step_t'(1);
            if (step_reg == step_t'(FIELD_DIMS - 1))
            begin
                busy_next = 1'b0;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = OFS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= RST_DIM_COUNT;
            layout_reg    <= LAYOUT_COL;
            busy_reg      <= 1'b1;
            step_reg      <= '0;
            acc_reg       <= OFS_W'(1);
        end
        else
        begin
            dim_count_reg <= dim_count_next;
            layout_reg    <= layout_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
        end
    end

    for (genvar j = 0; j < FIELD_DIMS; j++)
    begin : g_size
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                size_reg[j] <= RST_SIZE;
            end
            else if (cfg_we && (cfg_index == cfg_idx_t'(REG_SIZE_BASE + cfg_idx_t'(j))))
            begin
                size_reg[j] <= cfg_data;
            end
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_stride
        always_ff @(posedge clk)
        begin
            if (busy_reg && (k == step_t'(j)))
            begin
                stride_reg[j] <= in_use ? acc_reg : '0;
            end
        end
        assign stride[j] = stride_reg[j];
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

/* rtl/nalo_lane.sv */
// ---------------------------------------------------------------------------
// nalo_lane
// one index times stride product, registered
// ---------------------------------------------------------------------------
`default_nettype none

module nalo_lane #(
    parameter int INDEX_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [INDEX_BITS-1:0] index,
    input  nalo_pkg::offset_t          stride,
    output nalo_pkg::offset_t          product
);
    import nalo_pkg::*;

    logic [OFS_W+INDEX_BITS-1:0] full;
    offset_t product_reg;

    assign full = index * stride;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= full[OFS_W-1:0];
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

/* rtl/nalo_merge.sv */
// ---------------------------------------------------------------------------
// nalo_merge
// two-stage adder tree over the lane products with output register
// ---------------------------------------------------------------------------
`default_nettype none

module nalo_merge #(
    parameter int LANES = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  nalo_pkg::offset_t  product [LANES],
    output logic               in_ready,
    input  wire logic          out_stall,
    output logic               out_valid,
    output nalo_pkg::offset_t  linear_offset
);
    import nalo_pkg::*;

    localparam int NPAIR = (LANES + 1) / 2;

    logic    pair_v_reg, sum_v_reg;
    logic    pair_en, sum_en;
    offset_t pair_next [NPAIR];
    offset_t pair_reg  [NPAIR];
    offset_t sum_next;
    offset_t sum_reg;

    assign sum_en  = !sum_v_reg || !out_stall;
    assign pair_en = !pair_v_reg || sum_en;

    for (genvar p = 0; p < NPAIR; p++)
    begin : g_pair
        if (2 * p + 1 < LANES)
        begin : g_two
            assign pair_next[p] = product[2*p] + product[2*p+1];
        end
        else
        begin : g_one
            assign pair_next[p] = product[2*p];
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int p = 0; p < NPAIR; p++)
        begin
            sum_next = sum_next + pair_reg[p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
        end
        else
        begin
            if (pair_en)
            begin
                pair_v_reg <= in_valid;
            end
            if (sum_en)
            begin
                sum_v_reg <= pair_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_en)
        begin
            pair_reg <= pair_next;
        end
        if (sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign in_ready      = pair_en;
    assign out_valid     = sum_v_reg;
    assign linear_offset = sum_reg;

endmodule

`default_nettype wire

/* rtl/nd_array_linear_offset_core.sv */
// ---------------------------------------------------------------------------
// nd_array_linear_offset_core
// row-major / column-major offset generator for an array of up to six dims
// ---------------------------------------------------------------------------
// path: an accepted word passes the lane product, pair and sum registers
// throughput: one word per cycle unless a rebuild or out_stall holds it up,
// set by the lane multipliers and adder tree; stride rebuild: one dimension
// per cycle through one 60x11 multiplier, after reset and after every write
// to a known register; in_stall is high and cfg_ready low meanwhile
// reset: count 3, column-major, all extents 1, output empty
`default_nettype none

`include "nd_array_linear_offset_core_defines.svh"

module nd_array_linear_offset_core #(
    parameter int MAX_DIMS   = 6,
    parameter int INDEX_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  nalo_pkg::cfg_idx_t         cfg_index,
    input  nalo_pkg::size_t            cfg_data,
    // index word
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [INDEX_BITS-1:0] index_dim0,
    input  wire logic [INDEX_BITS-1:0] index_dim1,
    input  wire logic [INDEX_BITS-1:0] index_dim2,
    input  wire logic [INDEX_BITS-1:0] index_dim3,
    input  wire logic [INDEX_BITS-1:0] index_dim4,
    input  wire logic [INDEX_BITS-1:0] index_dim5,
    // offset word
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output nalo_pkg::offset_t          linear_offset
);
    import nalo_pkg::*;

    // lanes beyond the saturating dimension limit would only ever see zero strides
    localparam int LANES = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

    logic                  busy;
    logic                  cfg_we;
    logic                  accept;
    logic                  lane_v_reg;
    logic                  lane_en;
    logic                  merge_ready;
    logic [INDEX_BITS-1:0] index_vec [FIELD_DIMS];
    offset_t               stride  [LANES];
    offset_t               product [LANES];

    assign index_vec[0] = index_dim0;
    assign index_vec[1] = index_dim1;
    assign index_vec[2] = index_dim2;
    assign index_vec[3] = index_dim3;
    assign index_vec[4] = index_dim4;
    assign index_vec[5] = index_dim5;

    // config writes only land outside a rebuild
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    nalo_stride_gen #(
        .LANES (LANES)
    ) u_stride_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .stride    (stride)
    );

    // lane stage moves when empty or when the tree takes its word
    assign lane_en  = !lane_v_reg || merge_ready;
    assign in_stall = busy || !lane_en;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_v_reg <= 1'b0;
        end
        else if (lane_en)
        begin
            lane_v_reg <= accept;
        end
    end

    // one multiplier per dimension; unused dimensions carry a zero stride
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        nalo_lane #(
            .INDEX_BITS (INDEX_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (accept),
            .index   (index_vec[j]),
            .stride  (stride[j]),
            .product (product[j])
        );
    end

    nalo_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (lane_v_reg),
        .product       (product),
        .in_ready      (merge_ready),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .linear_offset (linear_offset)
    );

    // no index word gets in while strides are being rebuilt
    `NALO_ASSERT_IMP(a_busy_blocks_input, clk, rst_n, busy, in_stall)
    // no register write while strides are being rebuilt
    `NALO_ASSERT_IMP(a_busy_blocks_cfg, clk, rst_n, busy, !cfg_ready)
    // a write to a known register always triggers a rebuild
    `NALO_ASSERT_NXT(a_write_rebuilds, clk, rst_n, cfg_we && (cfg_index < REG_COUNT), busy)

endmodule

`default_nettype wire
